/* sv/gfrr_pkg.sv */
package gfrr_pkg;

  // ring geometry, power of two
  localparam int unsigned DEPTH = 2048;
  localparam int unsigned PTR_W = $clog2(DEPTH);

  // field widths
  localparam int unsigned DATA_W = 8;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned FILL_W = 11;
  localparam int unsigned LLT_W  = 16;
  localparam int unsigned HWP_W  = 7;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned LEN_W  = 16;

  // register reset values
  localparam logic [LLT_W-1:0] LLT_RESET = LLT_W'(3000);
  localparam logic [HWP_W-1:0] HWP_RESET = HWP_W'(75);

  // high-water level floor(DEPTH * pct / 100), pct < 128, so below 2 * DEPTH
  localparam int unsigned HW_W     = PTR_W + 1;
  localparam int unsigned HW_SHIFT = 30;
  localparam int unsigned RECIP_W  = 24;
  localparam logic [RECIP_W-1:0] HW_RECIP =
    RECIP_W'(((64'd1 << HW_SHIFT) + 64'd99) / 64'd100);
  localparam logic [HW_W-1:0] HW_RESET = HW_W'(DEPTH * 75 / 100);

  // frame header
  localparam logic [DATA_W-1:0] SYNC1 = 8'hB5;
  localparam logic [DATA_W-1:0] SYNC2 = 8'h62;
  localparam int unsigned HDR_MIN = 6;

  // register index
  localparam logic CFG_LINK_LOSS  = 1'b0;
  localparam logic CFG_HIGH_WATER = 1'b1;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_QUERY = 2'd2,
    OP_NOTE  = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [DATA_W-1:0] data_byte;
    logic [TIME_W-1:0] now_time;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_byte;
    logic              read_valid;
    logic              frame_ready;
    logic              byte_dropped;
    logic              flushed;
    logic              link_lost_flag;
    logic [FILL_W-1:0] fill_level;
  } out_item_t;

  // reciprocal multiply, exact for every 7-bit percent
  function automatic logic [HW_W-1:0] hw_level(input logic [HWP_W-1:0] pct);
    logic [HWP_W+PTR_W-1:0]         scaled;
    logic [HWP_W+PTR_W+RECIP_W-1:0] prod;
    scaled = {pct, {PTR_W{1'b0}}};
    prod   = (HWP_W+PTR_W+RECIP_W)'(scaled) * (HWP_W+PTR_W+RECIP_W)'(HW_RECIP);
    return prod[HW_SHIFT +: HW_W];
  endfunction

endpackage

/* sv/gnss_frame_rx_ring.sv */
// byte ring for a serial receive link, holding up to DEPTH-1 bytes
// input channel: in_valid_i / in_ready_o carry one command beat (write, read,
// frame query, note valid frame) with a data byte and the current ms time
// output channel: out_valid_o / out_ready_i carry exactly one result beat per
// command; the result sits in an output register
// config: cfg_we_i writes link_loss_time (index 0) or high_water_percent
// (index 1); the high-water level is updated at the same edge
// steps from accept to result: write and note finish in the execute state,
// a read waits in the read-wait state for the byte store, and a query walks
// the stored bytes one per cycle through the single read port of the byte
// store; a query on fewer than six bytes finishes in the execute state
// one command is worked at a time, so a beat is not taken until the
// previous command is through; the next beat is taken once the previous
// one has moved its result into the output register
// a receiver stall holds the finished result; a new command may be accepted
// meanwhile and waits before its final step until the register frees up
// reset empties the ring, clears the link-lost mark and the last frame time
// and loads the register defaults; the byte store is not cleared
module gnss_frame_rx_ring (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  gfrr_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output gfrr_pkg::out_item_t  out_data_o,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [gfrr_pkg::CFG_W-1:0] cfg_wdata_i
);

  localparam int unsigned PW    = gfrr_pkg::PTR_W;
  localparam int unsigned SUM_W = gfrr_pkg::PTR_W + gfrr_pkg::LEN_W + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RD_WAIT,
    S_SCAN,
    S_QDONE
  } state_e;

  state_e                          state_q, state_d;
  gfrr_pkg::in_item_t              item_q, item_d;
  logic [PW-1:0]                   wp_q, wp_d, rp_q, rp_d;
  logic [gfrr_pkg::TIME_W-1:0]     last_q, last_d;
  logic                            lost_q, lost_d;
  logic [gfrr_pkg::LLT_W-1:0]      llt_q, llt_d;
  logic [gfrr_pkg::HWP_W-1:0]      pct_q, pct_d;
  logic [gfrr_pkg::HW_W-1:0]       hw_q;
  logic [PW-1:0]                   cnt_q, cnt_d, rcv_q, rcv_d;
  logic [4:0][gfrr_pkg::DATA_W-1:0] win_q, win_d;
  logic                            found_q, found_d;
  logic                            out_valid_q, out_valid_d;
  gfrr_pkg::out_item_t             out_q, out_d;

  logic [PW-1:0]                   held, used_w;
  logic                            full, slot_free, stale;
  logic [gfrr_pkg::TIME_W-1:0]     elapsed;
  logic                            hdr_hit, scan_last;
  logic [SUM_W-1:0]                frame_end;
  logic                            ram_we, ram_re;
  logic [PW-1:0]                   ram_raddr;
  logic [gfrr_pkg::DATA_W-1:0]     ram_rdata;

  gfrr_ram #(
    .WIDTH(gfrr_pkg::DATA_W),
    .DEPTH(gfrr_pkg::DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wp_q),
    .wdata_i(item_q.data_byte),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign held      = wp_q - rp_q;
  assign full      = (held == PW'(gfrr_pkg::DEPTH - 1));
  assign slot_free = !out_valid_q || out_ready_i;
  assign used_w    = full ? held : held + PW'(1);
  assign elapsed   = item_q.now_time - last_q;
  assign stale     = (last_q != '0) && (gfrr_pkg::HW_W'(used_w) > hw_q) &&
                     (elapsed > gfrr_pkg::TIME_W'(llt_q));
  assign ram_raddr = rp_q + cnt_q;

  // window holds offsets rcv-1 (index 0) down to rcv-5 (index 4)
  assign frame_end = SUM_W'(rcv_q) + SUM_W'(3) + SUM_W'({ram_rdata, win_q[0]});
  assign hdr_hit   = (rcv_q >= PW'(5)) && (win_q[4] == gfrr_pkg::SYNC1) &&
                     (win_q[3] == gfrr_pkg::SYNC2) && (frame_end <= SUM_W'(held));
  assign scan_last = (rcv_q == held - PW'(1));

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    wp_d        = wp_q;
    rp_d        = rp_q;
    last_d      = last_q;
    lost_d      = lost_q;
    llt_d       = llt_q;
    pct_d       = pct_q;
    cnt_d       = cnt_q;
    rcv_d       = rcv_q;
    win_d       = win_q;
    found_d     = found_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        gfrr_pkg::CFG_LINK_LOSS:  llt_d = cfg_wdata_i[gfrr_pkg::LLT_W-1:0];
        gfrr_pkg::CFG_HIGH_WATER: pct_d = cfg_wdata_i[gfrr_pkg::HWP_W-1:0];
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_data_i;
          cnt_d   = '0;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        case (item_q.opcode)
          gfrr_pkg::OP_WRITE: begin
            if (slot_free) begin
              ram_we = !full;
              out_d  = '0;
              out_d.byte_dropped = full;
              if (stale) begin
                wp_d   = '0;
                rp_d   = '0;
                lost_d = 1'b1;
                out_d.flushed = 1'b1;
              end else begin
                wp_d = full ? wp_q : wp_q + PW'(1);
                out_d.fill_level = gfrr_pkg::FILL_W'(used_w);
              end
              out_d.link_lost_flag = stale || lost_q;
              out_valid_d = 1'b1;
              state_d     = S_IDLE;
            end
          end
          gfrr_pkg::OP_READ: begin
            if (held != '0) begin
              ram_re  = 1'b1;
              state_d = S_RD_WAIT;
            end else if (slot_free) begin
              out_d = '0;
              out_d.link_lost_flag = lost_q;
              out_valid_d = 1'b1;
              state_d     = S_IDLE;
            end
          end
          gfrr_pkg::OP_QUERY: begin
            if (held >= PW'(gfrr_pkg::HDR_MIN)) begin
              ram_re  = 1'b1;
              cnt_d   = PW'(1);
              rcv_d   = '0;
              state_d = S_SCAN;
            end else if (slot_free) begin
              out_d = '0;
              out_d.link_lost_flag = lost_q;
              out_d.fill_level     = gfrr_pkg::FILL_W'(held);
              out_valid_d = 1'b1;
              state_d     = S_IDLE;
            end
          end
          default: begin
            if (slot_free) begin
              last_d = item_q.now_time;
              out_d  = '0;
              out_d.link_lost_flag = lost_q;
              out_d.fill_level     = gfrr_pkg::FILL_W'(held);
              out_valid_d = 1'b1;
              state_d     = S_IDLE;
            end
          end
        endcase
      end
      S_RD_WAIT: begin
        // read data holds while the port is idle
        if (slot_free) begin
          rp_d  = rp_q + PW'(1);
          out_d = '0;
          out_d.read_byte      = ram_rdata;
          out_d.read_valid     = 1'b1;
          out_d.link_lost_flag = lost_q;
          out_d.fill_level     = gfrr_pkg::FILL_W'(held - PW'(1));
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_SCAN: begin
        ram_re = 1'b1;
        cnt_d  = cnt_q + PW'(1);
        rcv_d  = rcv_q + PW'(1);
        win_d  = {win_q[3:0], ram_rdata};
        if (hdr_hit || scan_last) begin
          found_d = hdr_hit;
          state_d = S_QDONE;
        end
      end
      S_QDONE: begin
        if (slot_free) begin
          out_d = '0;
          out_d.frame_ready    = found_q;
          out_d.link_lost_flag = lost_q;
          out_d.fill_level     = gfrr_pkg::FILL_W'(held);
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      item_q      <= '0;
      wp_q        <= '0;
      rp_q        <= '0;
      last_q      <= '0;
      lost_q      <= 1'b0;
      llt_q       <= gfrr_pkg::LLT_RESET;
      pct_q       <= gfrr_pkg::HWP_RESET;
      hw_q        <= gfrr_pkg::HW_RESET;
      cnt_q       <= '0;
      rcv_q       <= '0;
      win_q       <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      item_q      <= item_d;
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      last_q      <= last_d;
      lost_q      <= lost_d;
      llt_q       <= llt_d;
      pct_q       <= pct_d;
      hw_q        <= gfrr_pkg::hw_level(pct_d);
      cnt_q       <= cnt_d;
      rcv_q       <= rcv_d;
      win_q       <= win_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  a_flush_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.flushed |->
      out_data_o.fill_level == '0 && out_data_o.link_lost_flag)
    else $error("flush result without empty ring or link-lost mark");

  a_lost_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lost_q |=> lost_q)
    else $error("link-lost mark cleared outside reset");

  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> held != PW'(gfrr_pkg::DEPTH - 1))
    else $error("byte stored into a full ring");

  a_read_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.read_valid |->
      !out_data_o.byte_dropped && !out_data_o.flushed && !out_data_o.frame_ready)
    else $error("read result carries flags of another command");

endmodule

/* sv/gfrr_ram.sv */
module gfrr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
